// File: design/e2q_pkg.sv
`default_nettype none
package e2q_pkg;

    localparam int ANGLE_WIDTH = 16;
    localparam int OUT_WIDTH   = 16;
    localparam int OUT_FRAC    = OUT_WIDTH - 2;
    localparam int IN_TDATA_W  = ((3 * ANGLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((4 * OUT_WIDTH + 7) / 8) * 8;

    // Rounding from Q30 down to the output fraction.
    localparam int RND_SH = 30 - OUT_FRAC;
    localparam logic [33:0] RND_HALF = (RND_SH > 0) ? (34'd1 << (RND_SH - 1)) : 34'd0;
    localparam logic [33:0] OUT_LIM  = 34'd1 << OUT_FRAC;

    // 2^33/pi turns an angle with 13 fraction bits into a 32-bit half-angle phase.
    localparam logic [32:0] TURN_SCALE = 33'd2734261102;
    // pi/2 in Q32 is 2^32 plus this low part.
    localparam logic [31:0] HALF_PI_LO = 32'd2451551556;
    localparam logic [29:0] OCT_SPAN   = 30'h2000_0000;
    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;

    localparam int NUM_ITER = 3;
    localparam logic [6:0] SIN_DIV [0:3] = '{7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [6:0] COS_DIV [0:3] = '{7'd90, 7'd56, 7'd30, 7'd12};
    localparam logic [31:0] SIN_RCP [0:3] = '{
        32'((64'd1 << 32) / 72), 32'((64'd1 << 32) / 42),
        32'((64'd1 << 32) / 20), 32'((64'd1 << 32) / 6)};
    localparam logic [31:0] COS_RCP [0:3] = '{
        32'((64'd1 << 32) / 90), 32'((64'd1 << 32) / 56),
        32'((64'd1 << 32) / 30), 32'((64'd1 << 32) / 12)};

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    typedef logic [29:0] t_ang;

    typedef struct packed {
        t_ang       x;
        logic [2:0] oct;
    } t_lane;

    typedef struct packed {
        t_lane yaw;
        t_lane pitch;
        t_lane roll;
    } t_front_word;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_fifo_stat;

    // The estimate from the reciprocal is the quotient or one below it.
    function automatic logic [29:0] quo_fix(input logic [29:0] v, input logic [29:0] qe,
                                            input logic [6:0] d);
        logic [36:0] prod;
        logic [36:0] rem;
        prod = qe * d;
        rem  = {7'd0, v} - prod;
        return (rem >= {30'd0, d}) ? qe + 30'd1 : qe;
    endfunction

endpackage
`default_nettype wire

// File: design/e2q_front.sv
`default_nettype none
module e2q_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [e2q_pkg::IN_TDATA_W-1:0]    i_data,
    input  wire e2q_pkg::t_fifo_stat               i_stat,
    output logic                                   o_push,
    output e2q_pkg::t_front_word                   o_word
);

    localparam int AW = e2q_pkg::ANGLE_WIDTH;

    logic [1:0]           r_vld;
    logic                 en;
    logic [31:0]          r_phase [0:2];
    e2q_pkg::t_lane       r_lane  [0:2];

    assign en      = !r_vld[1] || !i_stat.full;
    assign o_ready = en;
    assign o_push  = r_vld[1] && !i_stat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic signed [AW-1:0] ang;
        logic signed [48:0]   prod;
        logic [2:0]           oct;
        logic [29:0]          oct_pos;
        logic [61:0]          prod2;
        logic [29:0]          n_x;

        always_comb begin
            ang  = $signed(i_data[k*AW +: AW]);
            prod = ang * $signed(e2q_pkg::TURN_SCALE);
        end

        // Fold the phase into one octant and scale it to radians in Q30.
        always_comb begin
            oct     = r_phase[k][31:29];
            oct_pos = {1'b0, r_phase[k][28:0]};
            if (oct[0]) begin
                oct_pos = e2q_pkg::OCT_SPAN - oct_pos;
            end
            prod2 = oct_pos * e2q_pkg::HALF_PI_LO;
            n_x   = oct_pos + prod2[61:32];
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_phase[k]    <= prod[47:16];
                r_lane[k].x   <= n_x;
                r_lane[k].oct <= oct;
            end
        end
    end

    assign o_word.roll  = r_lane[0];
    assign o_word.pitch = r_lane[1];
    assign o_word.yaw   = r_lane[2];

endmodule
`default_nettype wire

// File: design/e2q_fifo.sv
`default_nettype none
module e2q_fifo (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire e2q_pkg::t_front_word   i_data,
    input  wire logic                   i_pop,
    output e2q_pkg::t_front_word        o_data,
    output e2q_pkg::t_fifo_stat         o_stat
);

    localparam int PW = e2q_pkg::PTR_W;

    e2q_pkg::t_front_word r_mem [0:e2q_pkg::FIFO_DEPTH-1];
    logic [PW-1:0]        r_wr_ptr;
    logic [PW-1:0]        r_rd_ptr;
    logic [PW:0]          r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data           = r_mem[r_rd_ptr];
    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.full      = (r_count == (PW+1)'(e2q_pkg::FIFO_DEPTH));

endmodule
`default_nettype wire

// File: design/e2q_trig.sv
`default_nettype none
module e2q_trig (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [29:0]   i_x,
    input  wire logic [2:0]    i_oct,
    output logic [30:0]        o_sin,
    output logic [30:0]        o_cos,
    output logic [2:0]         o_oct
);

    localparam int NI = e2q_pkg::NUM_ITER;

    logic [29:0] r_x    [0:11];
    logic [29:0] r_x2   [0:11];
    logic [2:0]  r_oct  [0:12];
    logic [29:0] r_qe_s [0:NI];
    logic [29:0] r_qe_c [0:NI];
    logic [30:0] r_t_s  [0:NI];
    logic [30:0] r_t_c  [0:NI];
    logic [29:0] r_p_s  [0:NI-1];
    logic [29:0] r_p_c  [0:NI-1];
    logic [29:0] r_pd_s [0:NI-1];
    logic [29:0] r_pd_c [0:NI-1];
    logic [30:0] r_sin;
    logic [30:0] r_cos;

    logic [59:0] m_x2;
    logic [61:0] m_q0_s;
    logic [61:0] m_q0_c;
    logic [60:0] m_sin;
    logic [60:0] m_cos;

    assign m_x2   = i_x * i_x;
    assign m_q0_s = r_x2[0] * e2q_pkg::SIN_RCP[0];
    assign m_q0_c = r_x2[0] * e2q_pkg::COS_RCP[0];
    assign m_sin  = r_x[11] * r_t_s[NI];
    assign m_cos  = r_x2[11] * r_t_c[NI];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= i_x;
            r_x2[0]  <= m_x2[59:30];
            r_oct[0] <= i_oct;
            for (int i = 1; i < 12; i++) begin
                r_x[i]  <= r_x[i-1];
                r_x2[i] <= r_x2[i-1];
            end
            for (int i = 1; i < 13; i++) begin
                r_oct[i] <= r_oct[i-1];
            end
            r_qe_s[0] <= m_q0_s[61:32];
            r_qe_c[0] <= m_q0_c[61:32];
            r_t_s[0]  <= e2q_pkg::Q30_ONE -
                         {1'b0, e2q_pkg::quo_fix(r_x2[1], r_qe_s[0], e2q_pkg::SIN_DIV[0])};
            r_t_c[0]  <= e2q_pkg::Q30_ONE -
                         {1'b0, e2q_pkg::quo_fix(r_x2[1], r_qe_c[0], e2q_pkg::COS_DIV[0])};
            r_sin     <= m_sin[60:30];
            r_cos     <= e2q_pkg::Q30_ONE - {1'b0, m_cos[60:31]};
        end
    end

    // Each Horner step takes three stages: multiply by x^2, estimate the
    // quotient by a reciprocal, then correct it and subtract from one.
    for (genvar k = 0; k < NI; k++) begin : g_iter
        logic [60:0] m_p_s;
        logic [60:0] m_p_c;
        logic [61:0] m_q_s;
        logic [61:0] m_q_c;

        assign m_p_s = r_x2[2+3*k] * r_t_s[k];
        assign m_p_c = r_x2[2+3*k] * r_t_c[k];
        assign m_q_s = r_p_s[k] * e2q_pkg::SIN_RCP[k+1];
        assign m_q_c = r_p_c[k] * e2q_pkg::COS_RCP[k+1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p_s[k]    <= m_p_s[59:30];
                r_p_c[k]    <= m_p_c[59:30];
                r_pd_s[k]   <= r_p_s[k];
                r_pd_c[k]   <= r_p_c[k];
                r_qe_s[k+1] <= m_q_s[61:32];
                r_qe_c[k+1] <= m_q_c[61:32];
                r_t_s[k+1]  <= e2q_pkg::Q30_ONE - {1'b0,
                    e2q_pkg::quo_fix(r_pd_s[k], r_qe_s[k+1], e2q_pkg::SIN_DIV[k+1])};
                r_t_c[k+1]  <= e2q_pkg::Q30_ONE - {1'b0,
                    e2q_pkg::quo_fix(r_pd_c[k], r_qe_c[k+1], e2q_pkg::COS_DIV[k+1])};
            end
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;
    assign o_oct = r_oct[12];

endmodule
`default_nettype wire

// File: design/e2q_back.sv
`default_nettype none
module e2q_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire e2q_pkg::t_front_word              i_word,
    input  wire e2q_pkg::t_fifo_stat               i_stat,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [e2q_pkg::OUT_TDATA_W-1:0]        o_data
);

    localparam int NST = 17;
    localparam int OW  = e2q_pkg::OUT_WIDTH;
    // Triple products: which yaw-pitch pair, and whether roll enters as sine.
    localparam int        PAIR_SEL [0:7] = '{0, 1, 0, 1, 2, 3, 2, 3};
    localparam logic [7:0] ROLL_SIN = 8'b1001_0110;
    localparam logic [3:0] SUB_MASK = 4'b1010;

    logic [NST-1:0] r_vld;
    logic           en;

    logic [30:0] sin_v [0:2];
    logic [30:0] cos_v [0:2];
    logic [2:0]  oct_v [0:2];
    logic [30:0] mag_s [0:2];
    logic [30:0] mag_c [0:2];
    logic        neg_s [0:2];
    logic        neg_c [0:2];

    logic [30:0] r_pr    [0:3];
    logic        r_pr_sg [0:3];
    logic [30:0] r_rs;
    logic [30:0] r_rc;
    logic        r_rs_sg;
    logic        r_rc_sg;
    logic [30:0] r_tp    [0:7];
    logic        r_tp_sg [0:7];
    logic signed [32:0] r_sum [0:3];
    logic [OW-1:0]      r_q   [0:3];

    assign en    = !r_vld[NST-1] || i_ready;
    assign o_pop = i_stat.not_empty && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_stat.not_empty};
        end
    end

    e2q_trig u_trig_roll (
        .i_clk (i_clk), .i_en (en), .i_x (i_word.roll.x), .i_oct (i_word.roll.oct),
        .o_sin (sin_v[0]), .o_cos (cos_v[0]), .o_oct (oct_v[0])
    );
    e2q_trig u_trig_pitch (
        .i_clk (i_clk), .i_en (en), .i_x (i_word.pitch.x), .i_oct (i_word.pitch.oct),
        .o_sin (sin_v[1]), .o_cos (cos_v[1]), .o_oct (oct_v[1])
    );
    e2q_trig u_trig_yaw (
        .i_clk (i_clk), .i_en (en), .i_x (i_word.yaw.x), .i_oct (i_word.yaw.oct),
        .o_sin (sin_v[2]), .o_cos (cos_v[2]), .o_oct (oct_v[2])
    );

    // Octant unfold: swap sine and cosine in octants 1, 2, 5 and 6, then
    // the signs follow the quadrant.
    for (genvar k = 0; k < 3; k++) begin : g_unfold
        logic swap;
        assign swap     = oct_v[k][1] ^ oct_v[k][0];
        assign mag_s[k] = swap ? cos_v[k] : sin_v[k];
        assign mag_c[k] = swap ? sin_v[k] : cos_v[k];
        assign neg_s[k] = oct_v[k][2];
        assign neg_c[k] = oct_v[k][2] ^ oct_v[k][1];
    end

    logic [61:0] m_pr [0:3];
    assign m_pr[0] = mag_c[2] * mag_c[1];
    assign m_pr[1] = mag_s[2] * mag_s[1];
    assign m_pr[2] = mag_s[2] * mag_c[1];
    assign m_pr[3] = mag_c[2] * mag_s[1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_pr[i] <= m_pr[i][60:30];
            end
            r_pr_sg[0] <= neg_c[2] ^ neg_c[1];
            r_pr_sg[1] <= neg_s[2] ^ neg_s[1];
            r_pr_sg[2] <= neg_s[2] ^ neg_c[1];
            r_pr_sg[3] <= neg_c[2] ^ neg_s[1];
            r_rs       <= mag_s[0];
            r_rc       <= mag_c[0];
            r_rs_sg    <= neg_s[0];
            r_rc_sg    <= neg_c[0];
        end
    end

    for (genvar t = 0; t < 8; t++) begin : g_triple
        logic [30:0] rm;
        logic        rsg;
        logic [61:0] m_tp;
        assign rm   = ROLL_SIN[t] ? r_rs : r_rc;
        assign rsg  = ROLL_SIN[t] ? r_rs_sg : r_rc_sg;
        assign m_tp = r_pr[PAIR_SEL[t]] * rm;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_tp[t]    <= m_tp[60:30];
                r_tp_sg[t] <= r_pr_sg[PAIR_SEL[t]] ^ rsg;
            end
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_comp
        logic signed [32:0] va;
        logic signed [32:0] vb;
        logic               neg;
        logic [32:0]        mag;
        logic [33:0]        mr;
        logic [33:0]        res;

        always_comb begin
            va = $signed({2'b00, r_tp[2*j]});
            vb = $signed({2'b00, r_tp[2*j+1]});
            if (r_tp_sg[2*j]) begin
                va = -va;
            end
            if (r_tp_sg[2*j+1]) begin
                vb = -vb;
            end
        end

        // Round half away from zero on the magnitude, then clamp to one.
        always_comb begin
            neg = r_sum[j][32];
            mag = neg ? 33'(-r_sum[j]) : 33'(r_sum[j]);
            mr  = ({1'b0, mag} + e2q_pkg::RND_HALF) >> e2q_pkg::RND_SH;
            if (mr > e2q_pkg::OUT_LIM) begin
                mr = e2q_pkg::OUT_LIM;
            end
            res = neg ? (34'd0 - mr) : mr;
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sum[j] <= SUB_MASK[j] ? (va - vb) : (va + vb);
                r_q[j]   <= res[OW-1:0];
            end
        end
    end

    always_comb begin
        o_data = '0;
        for (int j = 0; j < 4; j++) begin
            o_data[j*OW +: OW] = r_q[j];
        end
    end

    assign o_valid = r_vld[NST-1];

endmodule
`default_nettype wire

// File: design/euler_to_quaternion.sv
`default_nettype none
// Channel   Direction  Word contents (lowest bits first)
// s_axis    in         roll, pitch, yaw: 16 bits each, signed, 13 fraction bits
// m_axis    out        quat_w, quat_x, quat_y, quat_z: 16 bits each, 14 fraction bits
//
// One angle triple is taken per cycle unless the queue is full and the front holds
// a word. The path runs through the two-stage phase front, the queue, and the Horner
// pipeline of the sine and cosine units followed by the product and rounding stages.
// Reset is synchronous and clears only the valid flags and the queue pointers and count.
// A stall on the output freezes the back pipeline while the front keeps
// filling the four-word queue until it is full.
module euler_to_quaternion (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // roll [15:0], pitch [31:16], yaw [47:32]
    input  wire logic [e2q_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
    output logic [e2q_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata
);

    e2q_pkg::t_fifo_stat  fifo_stat;
    e2q_pkg::t_front_word front_word;
    e2q_pkg::t_front_word head_word;
    logic                 push;
    logic                 pop;

    e2q_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .i_stat  (fifo_stat),
        .o_push  (push),
        .o_word  (front_word)
    );

    e2q_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_word),
        .i_pop   (pop),
        .o_data  (head_word),
        .o_stat  (fifo_stat)
    );

    e2q_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (head_word),
        .i_stat  (fifo_stat),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    localparam int RUN_LIMIT = 400000;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        bit                 fixed;
        logic [15:0]        w;
        logic [15:0]        x;
        logic [15:0]        y;
        logic [15:0]        z;
    } t_angle_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_axis_tvalid;
    logic                            o_s_axis_tready;
    logic [e2q_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready;
    logic [e2q_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;

    logic [63:0] quat_queue [$];
    int          error_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    euler_to_quaternion dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic void add_row(ref t_angle_row q [$], input t_angle_row row);
        q.insert(q.size(), row);
    endfunction

    function automatic longint unsigned sine_series(input longint unsigned a);
        longint unsigned a2;
        longint unsigned t;
        a2 = (a * a) >> 30;
        t = (64'd1 << 30) - a2 / 72;
        t = (64'd1 << 30) - ((a2 * t) >> 30) / 42;
        t = (64'd1 << 30) - ((a2 * t) >> 30) / 20;
        t = (64'd1 << 30) - ((a2 * t) >> 30) / 6;
        return (a * t) >> 30;
    endfunction

    function automatic longint unsigned cosine_series(input longint unsigned a);
        longint unsigned a2;
        longint unsigned t;
        a2 = (a * a) >> 30;
        t = (64'd1 << 30) - a2 / 90;
        t = (64'd1 << 30) - ((a2 * t) >> 30) / 56;
        t = (64'd1 << 30) - ((a2 * t) >> 30) / 30;
        t = (64'd1 << 30) - ((a2 * t) >> 30) / 12;
        return (64'd1 << 30) - ((a2 * t) >> 30) / 2;
    endfunction

    // Sine and cosine of half the angle, Q30, through a 32-bit phase in turns.
    function automatic void half_angle_trig(input logic signed [15:0] ang,
                                            output longint s, output longint c);
        longint unsigned a;
        longint unsigned phase;
        longint unsigned part;
        longint unsigned arg;
        longint          sv;
        longint          cv;
        int unsigned     oct;
        a = longint'(ang);
        phase = ((a * 64'd2734261102) >> 16) & 64'hFFFF_FFFF;
        oct = int'(phase >> 29);
        part = phase & ((64'd1 << 29) - 1);
        if (oct[0]) begin
            part = (64'd1 << 29) - part;
        end
        arg = (part * 64'd6746518852) >> 32;
        sv = longint'(sine_series(arg));
        cv = longint'(cosine_series(arg));
        if (((oct + 1) >> 1) & 1) begin
            s = cv;
            c = sv;
        end else begin
            s = sv;
            c = cv;
        end
        if (oct >= 4) s = -s;
        if (oct >= 2 && oct <= 5) c = -c;
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint          r;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        r = longint'((ma * mb) >> 30);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic logic [15:0] round_saturate(input longint v);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        m = (m + (64'd1 << 15)) >> 16;
        if (m > (64'd1 << 14)) m = 64'd1 << 14;
        return (v < 0) ? 16'(-m) : 16'(m);
    endfunction

    function automatic logic [63:0] predict_quaternion(input logic signed [15:0] roll,
            input logic signed [15:0] pitch, input logic signed [15:0] yaw);
        longint sr, cr, sp, cp, sy, cy;
        longint w, qx, qy, qz;
        half_angle_trig(roll, sr, cr);
        half_angle_trig(pitch, sp, cp);
        half_angle_trig(yaw, sy, cy);
        w  = q30_mul(q30_mul(cy, cp), cr) + q30_mul(q30_mul(sy, sp), sr);
        qx = q30_mul(q30_mul(cy, cp), sr) - q30_mul(q30_mul(sy, sp), cr);
        qy = q30_mul(q30_mul(sy, cp), sr) + q30_mul(q30_mul(cy, sp), cr);
        qz = q30_mul(q30_mul(sy, cp), cr) - q30_mul(q30_mul(cy, sp), sr);
        return {round_saturate(qz), round_saturate(qy), round_saturate(qx),
                round_saturate(w)};
    endfunction

    // Sends one angle triple; the expected word is queued at acceptance.
    task automatic send_angles(input logic signed [15:0] roll, input logic signed [15:0] pitch,
                               input logic signed [15:0] yaw, input logic [63:0] quat);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {yaw, pitch, roll};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        quat_queue.insert(quat_queue.size(), quat);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (quat_queue.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time,
                         o_m_axis_tdata);
                error_count <= error_count + 1;
            end else begin
                if (quat_queue[0] != o_m_axis_tdata) begin
                    $display("%0t: mismatch w/x/y/z, expected %h, actual %h", $time,
                             quat_queue[0], o_m_axis_tdata);
                    error_count <= error_count + 1;
                end
                void'(quat_queue.pop_front());
            end
        end
        if (cycle_count > RUN_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_angle_row rows [$];
        t_angle_row r;
        int p;
        int k;
        int sel;
        logic signed [15:0] ang [3];
        error_count     = 0;
        cycle_count     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero angles give the identity rotation.
        add_row(rows, '{16'sd0, 16'sd0, 16'sd0, 1'b1, 16'h4000, 16'h0, 16'h0, 16'h0});
        add_row(rows, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 0, 0, 0, 0});
        add_row(rows, '{-16'sh8000, -16'sh8000, -16'sh8000, 1'b0, 0, 0, 0, 0});
        add_row(rows, '{16'sh7FFF, -16'sh8000, 16'sd0, 1'b0, 0, 0, 0, 0});
        add_row(rows, '{-16'sh8000, 16'sd0, 16'sh7FFF, 1'b0, 0, 0, 0, 0});
        add_row(rows, '{16'sd1, -16'sd1, 16'sd1, 1'b0, 0, 0, 0, 0});
        add_row(rows, '{-16'sd1, -16'sd1, -16'sd1, 1'b0, 0, 0, 0, 0});
        // Quarter and half turns, octant borders of the half angle.
        add_row(rows, '{16'sd12868, 16'sd0, 16'sd0, 1'b0, 0, 0, 0, 0});
        add_row(rows, '{16'sd0, 16'sd12868, 16'sd0, 1'b0, 0, 0, 0, 0});
        add_row(rows, '{16'sd0, 16'sd0, 16'sd12868, 1'b0, 0, 0, 0, 0});
        add_row(rows, '{16'sd25736, 16'sd0, 16'sd0, 1'b0, 0, 0, 0, 0});
        add_row(rows, '{16'sd0, -16'sd25736, 16'sd0, 1'b0, 0, 0, 0, 0});
        add_row(rows, '{16'sd6434, 16'sd6434, 16'sd6434, 1'b0, 0, 0, 0, 0});
        add_row(rows, '{-16'sd6434, 16'sd19302, -16'sd19302, 1'b0, 0, 0, 0, 0});
        add_row(rows, '{16'sd0, 16'sd12868, 16'sd12868, 1'b0, 0, 0, 0, 0});
        add_row(rows, '{16'sh5555, 16'shAAAA, 16'sh5555, 1'b0, 0, 0, 0, 0});
        foreach (rows[i]) begin
            r = rows[i];
            send_angles(r.roll, r.pitch, r.yaw,
                        r.fixed ? {r.z, r.y, r.x, r.w}
                                : predict_quaternion(r.roll, r.pitch, r.yaw));
        end

        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            for (k = 0; k < 450; k++) begin
                for (int j = 0; j < 3; j++) begin
                    sel = $urandom_range(9);
                    if (sel < 6) ang[j] = 16'($urandom_range(25736 * 2) - 25736);
                    else if (sel < 8) ang[j] = 16'($urandom);
                    else ang[j] = 16'($urandom_range(7) - 4);
                end
                send_angles(ang[0], ang[1], ang[2], predict_quaternion(ang[0], ang[1], ang[2]));
            end
        end

        i_s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (quat_queue.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
design/e2q_pkg.sv
design/e2q_front.sv
design/e2q_fifo.sv
design/e2q_trig.sv
design/e2q_back.sv
design/euler_to_quaternion.sv
verif/testbench.sv
